### hw/rtl/ipv4p_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ipv4p_pkg: shared types and constants of the dotted IPv4 address parser
// Request and result payloads, the character class passed from the front
// end to the parse engine, and the character and range constants.
// ---------------------------------------------------------------------------
package ipv4p_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [31:0] address;
        logic        ok;
    } out_item_t;

    // One character after classification.
    typedef struct packed {
        logic       last;
        logic       is_dec;
        logic       is_oct;
        logic       is_hex;
        logic       is_x;
        logic       is_zero;
        logic       is_dot;
        logic       is_term;
        logic [3:0] digit;
    } char_class_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    localparam logic [31:0] MAX_LAST24 = 32'h00ff_ffff;
    localparam logic [31:0] MAX_LAST16 = 32'h0000_ffff;
    localparam logic [31:0] MAX_LAST8  = 32'h0000_00ff;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

endpackage
`default_nettype wire

### hw/rtl/ipv4p_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ipv4p_front: character intake and classification
// Takes a character request when the queue has room and tags it with the
// character classes and digit value that the parse engine needs.
// ---------------------------------------------------------------------------
module ipv4p_front (
    input  wire logic                   char_valid,
    output logic                        char_ready,
    input  wire ipv4p_pkg::in_item_t    char_item,
    input  wire logic                   queue_full,
    output logic                        push,
    output ipv4p_pkg::char_class_t      push_item
);

    logic [7:0] c;

    assign c          = char_item.ch;
    assign char_ready = !queue_full;
    assign push       = char_valid && !queue_full;

    always_comb
    begin
        push_item.last    = char_item.last_char;
        push_item.is_dec  = c inside {[ipv4p_pkg::CH_0:ipv4p_pkg::CH_9]};
        push_item.is_oct  = c inside {[ipv4p_pkg::CH_0:ipv4p_pkg::CH_7]};
        push_item.is_hex  = c inside {[ipv4p_pkg::CH_0:ipv4p_pkg::CH_9],
                                      [ipv4p_pkg::CH_UC_A:ipv4p_pkg::CH_UC_F],
                                      [ipv4p_pkg::CH_LC_A:ipv4p_pkg::CH_LC_F]};
        push_item.is_x    = c inside {ipv4p_pkg::CH_UC_X, ipv4p_pkg::CH_LC_X};
        push_item.is_zero = (c == ipv4p_pkg::CH_0);
        push_item.is_dot  = (c == ipv4p_pkg::CH_DOT);
        push_item.is_term = c inside {ipv4p_pkg::CH_NUL, ipv4p_pkg::CH_SPACE,
                                      [ipv4p_pkg::CH_TAB:ipv4p_pkg::CH_CR]};
        // Letters carry their value in the low nibble offset by nine.
        if (push_item.is_dec)
        begin
            push_item.digit = c[3:0];
        end
        else
        begin
            push_item.digit = c[3:0] + 4'd9;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ipv4p_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ipv4p_queue: classified character queue
// A short first-in first-out buffer that lets the front end and the parse
// engine stall independently.
// ---------------------------------------------------------------------------
module ipv4p_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire ipv4p_pkg::char_class_t      push_item,
    output logic                             full,
    input  wire logic                        pop,
    output logic                             q_valid,
    output ipv4p_pkg::char_class_t           q_item
);

    ipv4p_pkg::char_class_t                   slot_reg [ipv4p_pkg::QUEUE_DEPTH];
    logic [ipv4p_pkg::QUEUE_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [ipv4p_pkg::QUEUE_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [ipv4p_pkg::QUEUE_CNT_W-1:0]        count_reg, count_next;

    localparam logic [ipv4p_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        ipv4p_pkg::QUEUE_PTR_W'(ipv4p_pkg::QUEUE_DEPTH - 1);
    localparam logic [ipv4p_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        ipv4p_pkg::QUEUE_CNT_W'(ipv4p_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == FULL_COUNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count above depth");

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_pop_needs_entry : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from an empty queue");

endmodule
`default_nettype wire

### hw/rtl/ipv4p_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ipv4p_back: parse engine and result register
// Runs the dotted-address state machine on one classified character per
// cycle while no result stalls, collects the parts and places a decided
// result in the output register.
// ---------------------------------------------------------------------------
module ipv4p_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  wire ipv4p_pkg::char_class_t      q_item,
    output logic                             pop,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output ipv4p_pkg::out_item_t             res_item
);

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_ZERO   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    phase_t                 phase_reg, phase_next;
    radix_t                 radix_reg, radix_next;
    logic [31:0]            accum_reg, accum_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   big_reg, big_next;
    logic [7:0]             part_reg [3];
    logic                   part_we;
    logic                   res_valid_reg, res_valid_next;
    ipv4p_pkg::out_item_t   res_item_reg, res_item_next;

    logic                   decide;
    logic                   run_digits;
    radix_t                 eff_radix;
    logic [31:0]            eff_accum;
    logic [31:0]            times_ten;
    ipv4p_pkg::out_item_t   res_out;

    // Combine the collected parts; big flags an earlier part above one byte.
    function automatic ipv4p_pkg::out_item_t assemble(
        input logic [31:0] a,
        input logic [1:0]  cnt,
        input logic [7:0]  p0,
        input logic [7:0]  p1,
        input logic [7:0]  p2,
        input logic        big
    );
        ipv4p_pkg::out_item_t r;
        logic                 fits;
        case (cnt)
            2'd0:
            begin
                fits      = 1'b1;
                r.address = a;
            end
            2'd1:
            begin
                fits      = (a <= ipv4p_pkg::MAX_LAST24);
                r.address = {p0, a[23:0]};
            end
            2'd2:
            begin
                fits      = (a <= ipv4p_pkg::MAX_LAST16);
                r.address = {p0, p1, a[15:0]};
            end
            default:
            begin
                fits      = (a <= ipv4p_pkg::MAX_LAST8);
                r.address = {p0, p1, p2, a[7:0]};
            end
        endcase
        r.ok = fits && !big;
        if (!r.ok)
        begin
            r.address = '0;
        end
        return r;
    endfunction

    assign pop       = q_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;
    assign times_ten = {eff_accum[28:0], 3'b000} + {eff_accum[30:0], 1'b0};

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        accum_next = accum_reg;
        cnt_next   = cnt_reg;
        big_next   = big_reg;
        part_we    = 1'b0;
        decide     = 1'b0;
        run_digits = 1'b0;
        eff_radix  = radix_reg;
        eff_accum  = accum_reg;
        res_out    = '0;

        case (phase_reg)
            PH_START:
            begin
                radix_next = RX_DEC;
                if (!q_item.is_dec)
                begin
                    decide     = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (q_item.is_zero)
                begin
                    accum_next = '0;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    accum_next = {28'd0, q_item.digit};
                    phase_next = PH_DIGITS;
                end
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (q_item.is_x)
                begin
                    radix_next = RX_HEX;
                end
                else
                begin
                    radix_next = RX_OCT;
                    run_digits = 1'b1;
                    eff_radix  = RX_OCT;
                    eff_accum  = '0;
                end
            end
            PH_DIGITS:
            begin
                run_digits = 1'b1;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (run_digits)
        begin
            if (eff_radix == RX_HEX && q_item.is_hex)
            begin
                accum_next = {eff_accum[27:0], q_item.digit};
            end
            else if (eff_radix == RX_OCT && q_item.is_oct)
            begin
                accum_next = {eff_accum[28:0], q_item.digit[2:0]};
            end
            else if (eff_radix == RX_DEC && q_item.is_dec)
            begin
                accum_next = times_ten + {28'd0, q_item.digit};
            end
            else if (q_item.is_dot)
            begin
                if (cnt_reg == 2'd3)
                begin
                    decide     = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    part_we    = 1'b1;
                    cnt_next   = cnt_reg + 2'd1;
                    big_next   = big_reg || (|eff_accum[31:8]);
                    phase_next = PH_START;
                end
            end
            else
            begin
                // Anything else ends the number; only a terminator can pass.
                decide     = 1'b1;
                phase_next = PH_DONE;
                if (q_item.is_term)
                begin
                    res_out = assemble(eff_accum, cnt_reg, part_reg[0], part_reg[1],
                                       part_reg[2], big_reg);
                end
            end
        end

        // The end of the string acts as a terminator if nothing has decided.
        if (q_item.last && !decide && phase_reg != PH_DONE)
        begin
            decide = 1'b1;
            if (phase_next != PH_START)
            begin
                res_out = assemble(accum_next, cnt_next, part_reg[0], part_reg[1],
                                   part_reg[2], big_next);
            end
        end

        if (q_item.last)
        begin
            phase_next = PH_START;
            radix_next = RX_DEC;
            cnt_next   = '0;
            big_next   = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (pop && decide)
        begin
            res_valid_next = 1'b1;
            res_item_next  = res_out;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            radix_reg     <= RX_DEC;
            cnt_reg       <= '0;
            big_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                cnt_reg   <= cnt_next;
                big_reg   <= big_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            accum_reg <= accum_next;
        end
        if (pop && part_we)
        begin
            part_reg[cnt_reg] <= eff_accum[7:0];
        end
        res_item_reg <= res_item_next;
    end

    a_fail_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_item_reg.ok |-> res_item_reg.address == '0)
        else $error("failed parse with nonzero address");

    a_big_needs_part : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !big_reg)
        else $error("oversize part flag without a stored part");

    a_last_rearms : assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.last |=> phase_reg == PH_START && cnt_reg == 2'd0)
        else $error("parser not rearmed after end of string");

endmodule
`default_nettype wire

### hw/rtl/ipv4_dotted_address_parser_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ipv4_dotted_address_parser_unit: dotted IPv4 address parser
// Parses a character stream as a classic dotted address (decimal, octal or
// hex parts, one to four parts) and gives one result per string.
//
//   channel  direction  payload      accepted when
//   char     in         in_item_t    char_valid && char_ready
//   addr     out        out_item_t   addr_valid && addr_ready
//
// One character is taken per cycle while the queue has room; the engine
// handles one queued character per cycle unless the result stalls, so
// the sustained rate is one character per cycle. A deciding character's
// result is registered after it leaves the queue. Reset clears the queue,
// the parse state and the result valid flag at once. A stalled result
// holds the engine; the two-entry queue then fills and char_ready drops.
// ---------------------------------------------------------------------------
module ipv4_dotted_address_parser_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    char_valid,
    output logic                         char_ready,
    input  wire ipv4p_pkg::in_item_t     char_item,
    output logic                         addr_valid,
    input  wire logic                    addr_ready,
    output ipv4p_pkg::out_item_t         addr_result
);

    logic                    queue_full;
    logic                    push;
    ipv4p_pkg::char_class_t  push_item;
    logic                    pop;
    logic                    q_valid;
    ipv4p_pkg::char_class_t  q_item;

    ipv4p_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    ipv4p_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    ipv4p_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .res_valid (addr_valid),
        .res_ready (addr_ready),
        .res_item  (addr_result)
    );

endmodule
`default_nettype wire
